>>> design/correlator_frame_deframer_assert.svh
// Assertion macros shared by the deframer modules.
// All checks sample on the rising clock and are off while reset is high.
`ifndef CORRELATOR_FRAME_DEFRAMER_ASSERT_SVH
`define CORRELATOR_FRAME_DEFRAMER_ASSERT_SVH

// Implication checked every cycle out of reset.
`define CFD_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CFD_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> design/cfd_pkg.sv
package cfd_pkg;

   localparam int SAMPLES_PER_FRAME = 576;
   localparam int HEADER_BYTES      = 32;
   localparam int FRAME_BYTES       = HEADER_BYTES + 8 * SAMPLES_PER_FRAME;
   localparam int POS_W             = $clog2(FRAME_BYTES);

   localparam logic [POS_W-1:0] POS_SYNC    = POS_W'(3);
   localparam logic [POS_W-1:0] POS_FRAME   = POS_W'(7);
   localparam logic [POS_W-1:0] POS_SECONDS = POS_W'(11);
   localparam logic [POS_W-1:0] POS_CHGAIN  = POS_W'(15);
   localparam logic [POS_W-1:0] POS_TIME    = POS_W'(23);
   localparam logic [POS_W-1:0] POS_AVERAGE = POS_W'(27);
   localparam logic [POS_W-1:0] POS_HEADER  = POS_W'(HEADER_BYTES - 1);
   localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);

   localparam logic [31:0] SYNC_RESET = 32'h5CDE_C0DE;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_DATA_W = 288;

   typedef enum logic [1:0] {
      KIND_HDR_OK  = 2'd0,
      KIND_HDR_BAD = 2'd1,
      KIND_SAMPLE  = 2'd2,
      KIND_LAST    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [23:0]        frame_count;
      logic [7:0]         station_id;
      logic [31:0]        seconds_count;
      logic [31:0]        channel_gain;
      logic signed [63:0] time_tag;
      logic signed [31:0] average_count;
      logic [31:0]        stand_pair;
      logic signed [20:0] sample_real;
      logic signed [20:0] sample_imag;
      logic signed [21:0] sample_weight;
   } result_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

>>> design/cfd_front.sv
module cfd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          byte_data,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   output logic                push,
   output cfd_pkg::result_type push_data
);
   import cfd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [63:0]      shift_ff, shift_in;
   logic [31:0]      low32;
   logic [31:0]      sync_exp_ff;
   logic [31:0]      sync_ff;
   logic [31:0]      frame_word_ff;
   logic [31:0]      seconds_ff;
   logic [31:0]      chgain_ff;
   logic [63:0]      time_tag_ff;
   logic [31:0]      average_ff;
   logic             is_header;
   logic             is_sample;

   assign shift_in = {shift_ff[55:0], byte_data};
   assign low32    = shift_in[31:0];

   // header region ends at a multiple of eight, so word alignment is just pos[2:0]
   assign is_header = (pos_ff == POS_HEADER);
   assign is_sample = (pos_ff >= POS_HDR_END) && (pos_ff[2:0] == 3'd7);
   assign pos_in    = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sync_exp_ff <= SYNC_RESET;
      end else begin
         if (byte_valid) pos_ff <= pos_in;
         if (csr_wr_en) sync_exp_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid) begin
         shift_ff <= shift_in;
         if (pos_ff == POS_SYNC)    sync_ff       <= swap32(low32);
         if (pos_ff == POS_FRAME)   frame_word_ff <= low32;
         if (pos_ff == POS_SECONDS) seconds_ff    <= low32;
         if (pos_ff == POS_CHGAIN)  chgain_ff     <= low32;
         if (pos_ff == POS_TIME)    time_tag_ff   <= shift_in;
         if (pos_ff == POS_AVERAGE) average_ff    <= low32;
      end
   end

   always_comb begin
      push_data = '0;
      if (is_header) begin
         push_data.kind          = (sync_ff == sync_exp_ff) ? KIND_HDR_OK : KIND_HDR_BAD;
         push_data.frame_count   = frame_word_ff[23:0];
         push_data.station_id    = frame_word_ff[31:24];
         push_data.seconds_count = seconds_ff;
         push_data.channel_gain  = chgain_ff;
         push_data.time_tag      = time_tag_ff;
         push_data.average_count = average_ff;
         push_data.stand_pair    = low32;
      end else begin
         push_data.kind          = (pos_ff == POS_LAST) ? KIND_LAST : KIND_SAMPLE;
         push_data.sample_real   = shift_in[63:43];
         push_data.sample_imag   = shift_in[42:22];
         push_data.sample_weight = shift_in[21:0];
      end
   end

   assign push = byte_valid && (is_header || is_sample);

`include "correlator_frame_deframer_assert.svh"
   `CFD_ASSERT_NEXT(a_pos_wrap, byte_valid && pos_ff == POS_LAST, pos_ff == '0, "frame did not wrap")
   `CFD_ASSERT_IMPL(a_pos_range, 1'b1, pos_ff <= POS_LAST, "byte position out of frame")

endmodule

>>> design/cfd_queue.sv
module cfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cfd_pkg::result_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output cfd_pkg::result_type pop_data
);
   import cfd_pkg::*;

   result_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

`include "correlator_frame_deframer_assert.svh"
   `CFD_ASSERT_IMPL(a_no_overflow, push, !full, "push into full queue")
   `CFD_ASSERT_IMPL(a_no_underflow, pop, not_empty, "pop from empty queue")
   `CFD_ASSERT_IMPL(a_count_range, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")

endmodule

>>> design/cfd_back.sv
module cfd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   input  cfd_pkg::result_type           q_data,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                    rsp_tuser
);
   import cfd_pkg::*;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic [1:0]            kind_ff;

   assign q_pop = q_not_empty && (!valid_ff || rsp_tready);

   assign data_in = {q_data.sample_weight, q_data.sample_imag, q_data.sample_real,
                     q_data.stand_pair, q_data.average_count, q_data.time_tag,
                     q_data.channel_gain, q_data.seconds_count, q_data.station_id,
                     q_data.frame_count};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= data_in;
         kind_ff <= q_data.kind;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

endmodule

>>> design/correlator_frame_deframer.sv
// Channel  Dir  Beat
// req_     in   one frame byte (tdata[7:0] = data_byte)
// rsp_     out  one header or sample result (kind on tuser, fields on tdata)
// csr_     in   expected_sync write, no handshake
//
// One byte per cycle while the queue is not full; each byte updates the position
// counter, the 64-bit shift register and, at header positions, the header field
// registers in the front section. A result reaches rsp_ through the queue and
// then the output register; the two-entry queue absorbs short rsp_ stalls.
// req_tready drops only while the queue is full. Synchronous reset restarts
// the frame at byte 0 and loads expected_sync with 0x5CDEC0DE.
module correlator_frame_deframer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] data_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [23:0] frame_count, [31:24] station_id, [63:32] seconds_count,
   // [95:64] channel_gain, [159:96] time_tag, [191:160] average_count,
   // [223:192] stand_pair, [244:224] sample_real, [265:245] sample_imag,
   // [287:266] sample_weight
   output logic [cfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,  // [1:0] result_kind
   input  logic                           csr_wr_en,
   input  logic [31:0]                    csr_wr_data
);
   import cfd_pkg::*;

   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_not_empty;
   result_type q_wr_data;
   result_type q_rd_data;
   logic       beat_in;

   assign req_tready = !q_full;
   assign beat_in    = req_tvalid && req_tready;

   cfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (beat_in),
      .byte_data   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (q_push),
      .push_data   (q_wr_data)
   );

   cfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_rd_data)
   );

   cfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_rd_data),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
